[rtl/mrhp_pkg.sv]
package mrhp_pkg;

    // parser phases
    typedef enum logic [1:0] {
        PH_WAIT,
        PH_ECHO1,
        PH_ECHO2,
        PH_FIELD
    } phase_t;

    localparam int CNT_W = 4;

    // reply characters
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_W_UP  = 8'h57;
    localparam logic [7:0] CHAR_W_LO  = 8'h77;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;

    // keep thresholds and dual-field read limits
    localparam logic [7:0]       KEEP_SINGLE  = 8'd13;
    localparam logic [7:0]       KEEP_DUAL    = 8'd32;
    localparam logic [CNT_W-1:0] DUAL_FIRST_READS  = 4'd2;
    localparam logic [CNT_W-1:0] DUAL_SECOND_READS = 4'd4;

    typedef struct packed {
        phase_t             phase;
        logic [CNT_W-1:0]   read_count;
        logic [31:0]        acc;
        logic               field_num;
    } parse_state_t;

    typedef struct packed {
        logic [31:0] value;
        logic        field_index;
        logic        last;
    } reply_t;

    // case-folded digit weight: 0-9, a-z -> 10-35, anything else 0
    function automatic logic [5:0] digit_weight(input logic [7:0] b);
        logic [7:0] f;
        f = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            f = b + 8'h20;
        end
        if (f >= 8'h30 && f <= 8'h39)
        begin
            return 6'(f - 8'h30);
        end
        else if (f >= 8'h61 && f <= 8'h7A)
        begin
            return 6'(f - 8'h61 + 8'd10);
        end
        return 6'd0;
    endfunction

endpackage

[rtl/mrhp_if.sv]
interface mrhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrhp_reply_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               field_index;
    logic               last;

    modport source (output valid, output value, output field_index, output last, input ready);
    modport sink (input valid, input value, input field_index, input last, output ready);
endinterface

[rtl/mrhp_step.sv]
module mrhp_step #(
    parameter int SINGLE_FIELD_READS = 10
) (
    input  mrhp_pkg::parse_state_t state_cur,
    input  logic [7:0]             rx_byte,
    input  logic                   two_mode,
    output mrhp_pkg::parse_state_t state_next,
    output logic                   res_valid,
    output mrhp_pkg::reply_t       res
);

    localparam logic [mrhp_pkg::CNT_W-1:0] SINGLE_LIMIT =
        mrhp_pkg::CNT_W'(SINGLE_FIELD_READS);

    logic                         is_w;
    logic                         term;
    logic                         done;
    logic [mrhp_pkg::CNT_W-1:0]   limit;
    logic [7:0]                   keep_above;
    logic [mrhp_pkg::CNT_W-1:0]   cnt_inc;
    logic [31:0]                  acc_upd;

    // field rules for the current mode and field
    always_comb
    begin
        is_w = (rx_byte == mrhp_pkg::CHAR_W_UP) || (rx_byte == mrhp_pkg::CHAR_W_LO);
        if (!two_mode)
        begin
            limit      = SINGLE_LIMIT;
            keep_above = mrhp_pkg::KEEP_SINGLE;
            term       = is_w;
        end
        else if (!state_cur.field_num)
        begin
            limit      = mrhp_pkg::DUAL_FIRST_READS;
            keep_above = mrhp_pkg::KEEP_DUAL;
            term       = is_w || (rx_byte == mrhp_pkg::CHAR_LF);
        end
        else
        begin
            limit      = mrhp_pkg::DUAL_SECOND_READS;
            keep_above = mrhp_pkg::KEEP_DUAL;
            term       = is_w;
        end
    end

    // digit accumulate and read count
    always_comb
    begin
        cnt_inc = state_cur.read_count + 1'b1;
        if (rx_byte > keep_above)
        begin
            acc_upd = {state_cur.acc[27:0], 4'h0}
                    + {26'd0, mrhp_pkg::digit_weight(rx_byte)};
        end
        else
        begin
            acc_upd = state_cur.acc;
        end
        done = term || (cnt_inc >= limit);
    end

    // phase sequencing
    always_comb
    begin
        state_next = state_cur;
        res_valid  = 1'b0;
        res        = '0;
        unique case (state_cur.phase)
            mrhp_pkg::PH_WAIT:
            begin
                if (rx_byte == mrhp_pkg::CHAR_QMARK)
                begin
                    state_next.phase      = mrhp_pkg::PH_ECHO1;
                    state_next.read_count = '0;
                    state_next.acc        = '0;
                    state_next.field_num  = 1'b0;
                end
            end
            mrhp_pkg::PH_ECHO1:
            begin
                if ((!two_mode && rx_byte == mrhp_pkg::CHAR_CR)
                    || (two_mode && rx_byte == mrhp_pkg::CHAR_LF))
                begin
                    state_next.phase      = mrhp_pkg::PH_FIELD;
                    state_next.read_count = '0;
                    state_next.acc        = '0;
                    state_next.field_num  = 1'b0;
                end
                else
                begin
                    state_next.phase = mrhp_pkg::PH_ECHO2;
                end
            end
            mrhp_pkg::PH_ECHO2:
            begin
                state_next.phase      = mrhp_pkg::PH_FIELD;
                state_next.read_count = '0;
                state_next.acc        = '0;
                state_next.field_num  = 1'b0;
            end
            mrhp_pkg::PH_FIELD:
            begin
                if (!done)
                begin
                    state_next.acc        = acc_upd;
                    state_next.read_count = cnt_inc;
                end
                else
                begin
                    res_valid = 1'b1;
                    // terminator byte is not kept
                    res.value = term ? state_cur.acc : acc_upd;
                    if (two_mode && !state_cur.field_num)
                    begin
                        res.field_index       = 1'b0;
                        res.last              = 1'b0;
                        state_next.phase      = mrhp_pkg::PH_FIELD;
                        state_next.read_count = '0;
                        state_next.acc        = '0;
                        state_next.field_num  = 1'b1;
                    end
                    else
                    begin
                        res.field_index       = two_mode;
                        res.last              = 1'b1;
                        state_next.phase      = mrhp_pkg::PH_WAIT;
                        state_next.read_count = '0;
                        state_next.acc        = '0;
                        state_next.field_num  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

[rtl/motor_reply_hex_parser.sv]
// Motor controller reply parser.
// Byte channel (rx_chan): one received serial byte per request, valid/ready.
// Reply channel (reply_chan): one decoded hex value per request, with
//   field_index (0 first field, 1 left speed) and last (reply complete).
// cfg_wr_en/cfg_wr_data write reply_mode (0 single value, 1 two values);
//   write it only while no reply is in progress.
// Each byte is parsed in the cycle it is accepted; the value it completes
//   appears on reply_chan on the next cycle.
// Throughput is one byte per cycle while the receiver takes held replies, set by
//   the registered state update feeding the one-entry reply register.
// While a reply is held and the receiver stalls, rx_chan.ready is low and
//   input waits; a held reply taken in the same cycle lets the next byte in.
// Reset: waiting for '?', mode 0, reply register empty.
module motor_reply_hex_parser #(
    parameter int SINGLE_FIELD_READS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    mrhp_byte_if.sink           rx_chan,
    mrhp_reply_if.source        reply_chan,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);

    localparam int MAX_READS = (SINGLE_FIELD_READS > 4) ? SINGLE_FIELD_READS : 4;

    mrhp_pkg::parse_state_t state_reg;
    mrhp_pkg::parse_state_t state_next;
    mrhp_pkg::reply_t       out_reg;
    mrhp_pkg::reply_t       step_res;
    logic                   step_valid;
    logic                   out_valid_reg;
    logic                   mode_reg;
    logic                   rx_take;

    assign rx_chan.ready = !out_valid_reg || reply_chan.ready;
    assign rx_take       = rx_chan.valid && rx_chan.ready;

    mrhp_step #(
        .SINGLE_FIELD_READS (SINGLE_FIELD_READS)
    ) u_step (
        .state_cur  (state_reg),
        .rx_byte    (rx_chan.rx_byte),
        .two_mode   (mode_reg),
        .state_next (state_next),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= mrhp_pkg::PH_WAIT;
            state_reg.read_count <= '0;
            state_reg.acc        <= '0;
            state_reg.field_num  <= 1'b0;
        end
        else if (rx_take)
        begin
            state_reg <= state_next;
        end
    end

    // reply register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rx_take && step_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (reply_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take && step_valid)
        begin
            out_reg <= step_res;
        end
    end

    assign reply_chan.valid       = out_valid_reg;
    assign reply_chan.value       = $signed(out_reg.value);
    assign reply_chan.field_index = out_reg.field_index;
    assign reply_chan.last        = out_reg.last;

    // checks
    a_left_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        reply_chan.valid && reply_chan.field_index |-> reply_chan.last)
        else $error("left speed value without last");

    a_result_from_field: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid |-> state_reg.phase == mrhp_pkg::PH_FIELD)
        else $error("result outside field phase");

    a_last_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take && step_valid && step_res.last |=> state_reg.phase == mrhp_pkg::PH_WAIT)
        else $error("parser did not return to wait after last value");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.read_count < mrhp_pkg::CNT_W'(MAX_READS))
        else $error("read count beyond field limit");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int SINGLE_READS  = 10;
    localparam int RAND_BYTES    = 1650;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DIR_ROWS      = 28;

    // one directed stimulus row; exp only used when typed is set
    typedef struct packed {
        logic             mode;
        logic [7:0]       b;
        logic             typed;
        mrhp_pkg::reply_t exp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    mrhp_byte_if  rx_if();
    mrhp_reply_if rep_if();

    motor_reply_hex_parser #(
        .SINGLE_FIELD_READS (SINGLE_READS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_chan     (rx_if),
        .reply_chan  (rep_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // shadow parser state
    logic                       p_mode;
    mrhp_pkg::phase_t           p_phase;
    logic [mrhp_pkg::CNT_W-1:0] p_cnt;
    logic [31:0]                p_acc;
    logic                       p_fnum;

    mrhp_pkg::reply_t exp_replies[$];
    logic [7:0]       reply_bytes[$];
    int               mismatches   = 0;
    int               parsed_bytes = 0;
    int               burst_left   = 0;
    int unsigned      cycle_cnt    = 0;

    // receiver stall pattern, reloaded whenever the 7-bit stall_tick wraps
    logic [15:0] stall_pat  = 16'hFFFF;
    logic [6:0]  stall_tick = '0;

    // directed rows: single-value replies, two-value replies, mode flip mid-reply
    dir_row_t dir_tab [DIR_ROWS] = '{
        {1'b0, mrhp_pkg::CHAR_QMARK, 1'b0, 34'h0},
        {1'b0, 8'h61,                1'b0, 34'h0},
        {1'b0, 8'h62,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b0, 34'h0},
        {1'b0, 8'h46,                1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1},
        {1'b0, mrhp_pkg::CHAR_QMARK, 1'b0, 34'h0},
        {1'b0, mrhp_pkg::CHAR_CR,    1'b0, 34'h0},
        {1'b0, mrhp_pkg::CHAR_W_UP,  1'b1, 32'h0, 1'b0, 1'b1},
        {1'b1, mrhp_pkg::CHAR_QMARK, 1'b0, 34'h0},
        {1'b1, mrhp_pkg::CHAR_LF,    1'b0, 34'h0},
        {1'b1, 8'h31,                1'b0, 34'h0},
        {1'b1, 8'h32,                1'b1, 32'h12, 1'b0, 1'b0},
        {1'b1, 8'h7A,                1'b0, 34'h0},
        {1'b1, mrhp_pkg::CHAR_LF,    1'b0, 34'h0},
        {1'b1, mrhp_pkg::CHAR_W_LO,  1'b0, 34'h0},
        {1'b1, mrhp_pkg::CHAR_QMARK, 1'b0, 34'h0},
        {1'b1, mrhp_pkg::CHAR_LF,    1'b0, 34'h0},
        {1'b1, mrhp_pkg::CHAR_W_UP,  1'b1, 32'h0, 1'b0, 1'b0},
        {1'b0, 8'h37,                1'b0, 34'h0},
        {1'b0, mrhp_pkg::CHAR_W_LO,  1'b0, 34'h0}
    };

    // digit weight (0-9, a-z -> 10-35) after ASCII case folding
    function automatic logic [5:0] char_weight(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= 8'h41 && c <= 8'h5A) ? c | 8'h20 : c;
        if (lc >= 8'h61 && lc <= 8'h7A)
        begin
            return 6'(lc - 8'h57);
        end
        if (lc >= 8'h30 && lc <= 8'h39)
        begin
            return 6'(lc - 8'h30);
        end
        return 6'd0;
    endfunction

    function automatic void open_field(input logic num);
        p_phase = mrhp_pkg::PH_FIELD;
        p_cnt   = '0;
        p_acc   = '0;
        p_fnum  = num;
    endfunction

    // advance the shadow parser by one byte; returns 1 when a value completes
    function automatic bit hex_step(input logic [7:0] b, output mrhp_pkg::reply_t r);
        logic [mrhp_pkg::CNT_W-1:0] limit;
        logic [7:0]                 keep_over;
        bit                         ends;
        r    = '0;
        ends = (b == mrhp_pkg::CHAR_W_UP || b == mrhp_pkg::CHAR_W_LO);
        case (p_phase)
            mrhp_pkg::PH_WAIT:
            begin
                if (b == mrhp_pkg::CHAR_QMARK)
                begin
                    p_phase = mrhp_pkg::PH_ECHO1;
                    p_cnt   = '0;
                    p_acc   = '0;
                    p_fnum  = 1'b0;
                end
                return 1'b0;
            end
            mrhp_pkg::PH_ECHO1:
            begin
                if ((!p_mode && b == mrhp_pkg::CHAR_CR) || (p_mode && b == mrhp_pkg::CHAR_LF))
                    open_field(1'b0);
                else
                    p_phase = mrhp_pkg::PH_ECHO2;
                return 1'b0;
            end
            mrhp_pkg::PH_ECHO2:
            begin
                open_field(1'b0);
                return 1'b0;
            end
            default:
            begin
            end
        endcase

        // field rules follow the current mode, not the field number alone
        if (!p_mode)
        begin
            limit     = mrhp_pkg::CNT_W'(SINGLE_READS);
            keep_over = mrhp_pkg::KEEP_SINGLE;
        end
        else if (!p_fnum)
        begin
            limit     = mrhp_pkg::DUAL_FIRST_READS;
            keep_over = mrhp_pkg::KEEP_DUAL;
            ends      = ends || (b == mrhp_pkg::CHAR_LF);
        end
        else
        begin
            limit     = mrhp_pkg::DUAL_SECOND_READS;
            keep_over = mrhp_pkg::KEEP_DUAL;
        end

        if (!ends)
        begin
            if (b > keep_over)
                p_acc = {p_acc[27:0], 4'h0} + 32'(char_weight(b));
            p_cnt = p_cnt + 1'b1;
            ends  = (p_cnt >= limit);
        end
        if (!ends)
            return 1'b0;

        if (p_mode && !p_fnum)
        begin
            r = {p_acc, 1'b0, 1'b0};
            open_field(1'b1);
        end
        else
        begin
            r       = {p_acc, p_mode, 1'b1};
            p_phase = mrhp_pkg::PH_WAIT;
            p_cnt   = '0;
            p_acc   = '0;
            p_fnum  = 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly digits and letters, some threshold and high bytes
    function automatic logic [7:0] field_byte();
        int         pick;
        int         wgt;
        logic [7:0] c;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            wgt = $urandom_range(0, 35);
            if (wgt < 10)
                c = 8'(8'h30 + wgt);
            else
            begin
                c = 8'(8'h57 + wgt);
                if ($urandom_range(0, 1) != 0)
                    c = c & 8'hDF;
            end
        end
        else if (pick == 6)
            c = 8'($urandom);
        else if (pick == 7)
            c = 8'($urandom_range(0, 40));
        else if (pick == 8)
            c = 8'($urandom_range(128, 255));
        else
            c = 8'($urandom_range(33, 127));
        return c;
    endfunction

    // append one value field, terminated early or filled to its read limit
    function automatic void push_field(input int max_reads, input bit lf_ends);
        int n;
        n = $urandom_range(0, max_reads);
        repeat (n) reply_bytes.push_back(field_byte());
        if (n < max_reads || $urandom_range(0, 7) == 0)
        begin
            if (lf_ends && $urandom_range(0, 2) == 0)
                reply_bytes.push_back(mrhp_pkg::CHAR_LF);
            else if ($urandom_range(0, 1) != 0)
                reply_bytes.push_back(mrhp_pkg::CHAR_W_UP);
            else
                reply_bytes.push_back(mrhp_pkg::CHAR_W_LO);
        end
    endfunction

    // one byte request: bursts with random gaps, predicts at acceptance
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input mrhp_pkg::reply_t typed_val);
        mrhp_pkg::reply_t r;
        int               gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        if (p_phase != mrhp_pkg::PH_WAIT || b == mrhp_pkg::CHAR_QMARK)
            parsed_bytes++;
        if (hex_step(b, r))
            exp_replies.push_back(typed ? typed_val : r);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (exp_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        p_mode = m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    // mostly well-formed replies, some noise and cut-off replies
    task automatic send_reply();
        int kind;
        int cut;
        reply_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6)) reply_bytes.push_back(8'($urandom));
        end
        else
        begin
            if (kind < 20)
                repeat ($urandom_range(1, 3)) reply_bytes.push_back(8'($urandom));
            reply_bytes.push_back(mrhp_pkg::CHAR_QMARK);
            if ($urandom_range(0, 1) != 0)
                reply_bytes.push_back(p_mode ? mrhp_pkg::CHAR_LF : mrhp_pkg::CHAR_CR);
            else
            begin
                reply_bytes.push_back(8'($urandom));
                reply_bytes.push_back(8'($urandom));
            end
            if (!p_mode)
                push_field(SINGLE_READS, 1'b0);
            else
            begin
                push_field(2, 1'b1);
                push_field(4, 1'b0);
            end
            if (kind >= 88)
            begin
                cut = $urandom_range(1, reply_bytes.size());
                while (reply_bytes.size() > cut)
                    void'(reply_bytes.pop_back());
            end
        end
        foreach (reply_bytes[i])
            send_byte(reply_bytes[i], 1'b0, '0);
    endtask

    // receiver ready pattern
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick == '0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pat <= 16'hFFFF;
                1: stall_pat <= 16'($urandom);
                2: stall_pat <= 16'($urandom & $urandom) | 16'h0001;
                default: stall_pat <= 16'hF0F0 ^ 16'($urandom_range(0, 255));
            endcase
        end
        else
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
        rep_if.ready <= stall_pat[0];
    end

    // compare each accepted reply with the oldest predicted one
    always @(posedge clk)
    begin : chk_reply
        mrhp_pkg::reply_t want;
        if (rst_n && rep_if.valid && rep_if.ready)
        begin
            if (exp_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: value=%0d index=%0d last=%0d",
                             rep_if.value, rep_if.field_index, rep_if.last);
            end
            else
            begin
                want = exp_replies.pop_front();
                if (rep_if.value !== want.value || rep_if.field_index !== want.field_index
                    || rep_if.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $signed(want.value), want.field_index, want.last,
                                 rep_if.value, rep_if.field_index, rep_if.last);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int phase_goal;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        p_mode  = 1'b0;
        p_phase = mrhp_pkg::PH_WAIT;
        p_cnt   = '0;
        p_acc   = '0;
        p_fnum  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].mode != p_mode)
                set_mode(dir_tab[i].mode);
            send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].exp);
        end

        // random replies, mode rewritten between stretches
        parsed_bytes = 0;
        for (int ph = 0; parsed_bytes < RAND_BYTES; ph++)
        begin
            set_mode((ph < 2) ? 1'(ph) : 1'($urandom_range(0, 1)));
            phase_goal = parsed_bytes + $urandom_range(60, 220);
            while (parsed_bytes < phase_goal && parsed_bytes < RAND_BYTES)
                send_reply();
        end

        wait_drained();
        if (mismatches == 0 && exp_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
